// ===== rtl/msd_pkg.sv =====
`default_nettype none

package msd_pkg;

    localparam int MAX_DELIM = 8;
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 4;
    localparam int FILL_W    = $clog2(MAX_DELIM);
    localparam int SEEN_MAX  = MAX_DELIM + 1;
    localparam int SEEN_W    = $clog2(SEEN_MAX + 1);
    localparam int COUNT_W   = 16;
    localparam int DELIM_W   = BYTE_W * MAX_DELIM;
    localparam int APB_DW    = 64;
    localparam int APB_AW    = 4;

    // Register select: address bit 3 (registers sit at 8-byte spacing)
    typedef enum logic
    {
        REG_DELIM_LEN   = 1'b0,
        REG_DELIM_BYTES = 1'b1
    } msd_reg_t;

    // Delimiter setup handed from the register block to the datapath
    typedef struct packed
    {
        logic [LEN_W-1:0]   delim_len;    // clamped to 1..MAX_DELIM
        logic [DELIM_W-1:0] delim_bytes;
    } msd_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/msd_cfg.sv =====
`default_nettype none

module msd_cfg
    import msd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output msd_cfg_t               cfg
);

    logic [LEN_W-1:0]   delim_len_reg;
    logic [DELIM_W-1:0] delim_bytes_reg;
    msd_reg_t           sel;
    logic               wr_en;

    assign sel    = msd_reg_t'(paddr[3]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_len_reg   <= LEN_W'(1);
            delim_bytes_reg <= DELIM_W'(13);
        end
        else if (wr_en)
        begin
            case (sel)
                REG_DELIM_LEN:   delim_len_reg   <= pwdata[LEN_W-1:0];
                REG_DELIM_BYTES: delim_bytes_reg <= pwdata[DELIM_W-1:0];
                default:         delim_len_reg   <= delim_len_reg;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            REG_DELIM_LEN:   prdata = APB_DW'(delim_len_reg);
            REG_DELIM_BYTES: prdata = APB_DW'(delim_bytes_reg);
            default:         prdata = '0;
        endcase
    end

    // Zero acts as one; anything above the window depth acts as the full depth
    always_comb
    begin
        cfg.delim_bytes = delim_bytes_reg;
        if (delim_len_reg == '0)
            cfg.delim_len = LEN_W'(1);
        else if (delim_len_reg > LEN_W'(MAX_DELIM))
            cfg.delim_len = LEN_W'(MAX_DELIM);
        else
            cfg.delim_len = delim_len_reg;
    end

endmodule

`default_nettype wire

// ===== rtl/multibyte_delimiter_splitter_top.sv =====
`default_nettype none

// An accepted item goes to the input register, then the result register. While result_stall
// is low: one result per cycle; one item per cycle while each item gives at most one result;
// an item with several results holds the input register, as there is a single result register.
// Reset: rst_n asynchronous, active low; clears string state, handshakes, and sets
// delim_len to 1 and delim_bytes to 13. The byte window is not cleared.
module multibyte_delimiter_splitter_top
    import msd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [APB_AW-1:0]  paddr,
    input  wire logic [APB_DW-1:0]  pwdata,
    output logic      [APB_DW-1:0]  prdata,
    output logic                    pready,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire logic [BYTE_W-1:0]  char_in,
    input  wire logic               is_final,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic      [BYTE_W-1:0]  char_out,
    output logic                    char_valid,
    output logic                    part_end,
    output logic                    string_end,
    output logic                    rejected,
    output logic      [COUNT_W-1:0] part_count
);

    msd_cfg_t cfg;

    msd_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input register
    logic              hold_valid_reg, hold_valid_next;
    logic [BYTE_W-1:0] char_reg;
    logic              final_reg;

    // String state
    logic [BYTE_W-1:0]  win_reg  [MAX_DELIM];
    logic [BYTE_W-1:0]  win_next [MAX_DELIM];
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [SEEN_W-1:0]  seen_reg, seen_next;
    logic [COUNT_W-1:0] parts_reg, parts_next;
    logic               flush_reg, flush_next;

    // Result register
    logic               out_valid_reg;
    logic [BYTE_W-1:0]  char_out_reg;
    logic               char_valid_reg;
    logic               part_end_reg;
    logic               string_end_reg;
    logic               rejected_reg;
    logic [COUNT_W-1:0] part_count_reg;

    // Step results
    logic               res_valid;
    logic [BYTE_W-1:0]  res_char;
    logic               res_char_valid;
    logic               res_part_end;
    logic               res_string_end;
    logic               res_rejected;
    logic [COUNT_W-1:0] res_count;

    logic               out_free;
    logic               step;
    logic               consume;
    logic               accept;
    logic [BYTE_W-1:0]  aw [MAX_DELIM];
    logic [LEN_W-1:0]   fill_ext;
    logic               drain;
    logic               full_after;
    logic               match;
    logic [SEEN_W-1:0]  seen_inc;
    logic [COUNT_W-1:0] total;

    assign out_free   = ~out_valid_reg | ~result_stall;
    assign step       = hold_valid_reg & out_free;
    assign item_stall = hold_valid_reg & ~consume;
    assign accept     = item_valid & ~item_stall;

    assign fill_ext   = LEN_W'(fill_reg);
    assign drain      = (fill_reg != '0) && (fill_ext >= cfg.delim_len);
    assign full_after = ((fill_ext + LEN_W'(1)) == cfg.delim_len);
    assign seen_inc   = (seen_reg == SEEN_W'(SEEN_MAX)) ? seen_reg : seen_reg + SEEN_W'(1);
    assign total      = (parts_reg == '1) ? parts_reg : parts_reg + COUNT_W'(1);

    // Window with the held byte placed after the stored bytes
    always_comb
    begin
        for (int i = 0; i < MAX_DELIM; i++)
        begin
            aw[i] = (FILL_W'(i) == fill_reg) ? char_reg : win_reg[i];
        end
    end

    always_comb
    begin
        match = 1'b1;
        for (int i = 0; i < MAX_DELIM; i++)
        begin
            if ((LEN_W'(i) < cfg.delim_len) && (aw[i] != cfg.delim_bytes[i*BYTE_W +: BYTE_W]))
                match = 1'b0;
        end
    end

    always_comb
    begin
        win_next       = win_reg;
        fill_next      = fill_reg;
        seen_next      = seen_reg;
        parts_next     = parts_reg;
        flush_next     = flush_reg;
        consume        = 1'b0;
        res_valid      = 1'b0;
        res_char       = '0;
        res_char_valid = 1'b0;
        res_part_end   = 1'b0;
        res_string_end = 1'b0;
        res_rejected   = 1'b0;
        res_count      = '0;

        if (step)
        begin
            if (flush_reg || drain)
            begin
                // Send the oldest held byte and advance the window
                res_valid      = 1'b1;
                res_char       = win_reg[0];
                res_char_valid = 1'b1;
                for (int i = 0; i < MAX_DELIM - 1; i++)
                    win_next[i] = win_reg[i+1];
                fill_next = fill_reg - FILL_W'(1);
                if (flush_reg && (fill_reg == FILL_W'(1)))
                begin
                    res_part_end   = 1'b1;
                    res_string_end = 1'b1;
                    res_count      = total;
                    consume        = 1'b1;
                    fill_next      = '0;
                    seen_next      = '0;
                    parts_next     = '0;
                    flush_next     = 1'b0;
                end
            end
            else if (final_reg)
            begin
                res_valid = 1'b1;
                consume   = 1'b1;
                fill_next  = '0;
                seen_next  = '0;
                parts_next = '0;
                if (SEEN_W'(seen_inc) <= SEEN_W'(cfg.delim_len))
                begin
                    res_string_end = 1'b1;
                    res_rejected   = 1'b1;
                end
                else if (full_after && match)
                begin
                    res_part_end   = 1'b1;
                    res_string_end = 1'b1;
                    res_count      = total;
                end
                else
                begin
                    res_char       = aw[0];
                    res_char_valid = 1'b1;
                    if (fill_reg == '0)
                    begin
                        res_part_end   = 1'b1;
                        res_string_end = 1'b1;
                        res_count      = total;
                    end
                    else
                    begin
                        // Hold the rest and flush one byte a cycle while the result register is free
                        consume    = 1'b0;
                        for (int i = 0; i < MAX_DELIM - 1; i++)
                            win_next[i] = aw[i+1];
                        fill_next  = fill_reg;
                        seen_next  = seen_inc;
                        parts_next = parts_reg;
                        flush_next = 1'b1;
                    end
                end
            end
            else
            begin
                consume   = 1'b1;
                seen_next = seen_inc;
                if (full_after && match)
                begin
                    res_valid    = 1'b1;
                    res_part_end = 1'b1;
                    fill_next    = '0;
                    parts_next   = total;
                end
                else if (full_after)
                begin
                    res_valid      = 1'b1;
                    res_char       = aw[0];
                    res_char_valid = 1'b1;
                    for (int i = 0; i < MAX_DELIM - 1; i++)
                        win_next[i] = aw[i+1];
                end
                else
                begin
                    win_next  = aw;
                    fill_next = fill_reg + FILL_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        if (accept)
            hold_valid_next = 1'b1;
        else if (consume)
            hold_valid_next = 1'b0;
        else
            hold_valid_next = hold_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            fill_reg       <= '0;
            seen_reg       <= '0;
            parts_reg      <= '0;
            flush_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            fill_reg       <= fill_next;
            seen_reg       <= seen_next;
            parts_reg      <= parts_next;
            flush_reg      <= flush_next;
            if (out_free)
                out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            char_reg  <= char_in;
            final_reg <= is_final;
        end
        win_reg <= win_next;
        if (out_free)
        begin
            char_out_reg   <= res_char;
            char_valid_reg <= res_char_valid;
            part_end_reg   <= res_part_end;
            string_end_reg <= res_string_end;
            rejected_reg   <= res_rejected;
            part_count_reg <= res_count;
        end
    end

    assign result_valid = out_valid_reg;
    assign char_out     = char_out_reg;
    assign char_valid   = char_valid_reg;
    assign part_end     = part_end_reg;
    assign string_end   = string_end_reg;
    assign rejected     = rejected_reg;
    assign part_count   = part_count_reg;

endmodule

`default_nettype wire
